// ===== sv/wav_riff_pkg.sv =====
// Package: types and constants for the RIFF/WAVE header parser.
package wav_riff_pkg;

  localparam logic [31:0] ID_RIFF        = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE        = 32'h4556_4157;
  localparam logic [31:0] ID_FMT         = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA        = 32'h6174_6164;
  localparam logic [31:0] FMT_WITH_EXTRA = 32'd18;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;

  typedef enum logic [3:0] {
    PH_ID        = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_RIFF_TYPE = 4'd2,
    PH_FMT_SIZE  = 4'd3,
    PH_FMT_TAG   = 4'd4,
    PH_FMT_CH    = 4'd5,
    PH_FMT_RATE  = 4'd6,
    PH_FMT_BRATE = 4'd7,
    PH_FMT_ALIGN = 4'd8,
    PH_FMT_DEPTH = 4'd9,
    PH_FMT_EXTRA = 4'd10,
    PH_DATA_SIZE = 4'd11,
    PH_SKIP_SIZE = 4'd12,
    PH_SKIP      = 4'd13,
    PH_DONE      = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_NOTPCM = 2'd1,
    ERR_NOTWAV = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_PARSING = 3'd0,
    ST_DONE    = 3'd1,
    ST_PAST    = 3'd2,
    ST_NOTPCM  = 3'd3,
    ST_NOTWAV  = 3'd4
  } status_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
  } out_item_t;

endpackage

// ===== sv/wav_riff_header_parser_unit.sv =====
// RIFF/WAVE header parser: one file byte per transaction in, one result out.
//
// Input channel (in_valid/in_stall/in_data): one file byte per transaction;
// in_data.restart marks the first byte of a new file and clears the parser.
// Output channel (out_valid/out_stall/out_data): exactly one result per input
// byte, in order. status: parsing, header complete on this byte, past header,
// not PCM, not WAVE. Decoded fields are valid under the two header statuses
// and zero otherwise.
// The result is presented in the cycle after its byte is taken.
// Throughput: one byte per cycle while no held result is stalled; the parse
// state and the result register both update in the cycle the byte is taken.
// Stall: a held result stays in the output register; in_stall follows
// out_stall while a result is held, so no byte is taken that has nowhere
// to go. When out_stall drops, a new byte may enter the same cycle.
// Reset (rst_n low, synchronous): parser returns to expecting a chunk id,
// all held values clear, and the output register is emptied.
module wav_riff_header_parser_unit
  import wav_riff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  field_bytes_r, field_bytes_nxt;
  logic [31:0] word_shift_r, word_shift_nxt;
  logic [31:0] skip_left_r, skip_left_nxt;
  logic [31:0] byte_position_r, byte_position_nxt;
  logic [31:0] fmt_length_r, fmt_length_nxt;
  logic [15:0] format_tag_r, format_tag_nxt;
  logic [15:0] held_channels_r, held_channels_nxt;
  logic [31:0] held_rate_r, held_rate_nxt;
  logic [15:0] held_depth_r, held_depth_nxt;
  logic [31:0] held_size_r, held_size_nxt;
  err_t        error_code_r, error_code_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;
  logic        in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_t      ph;
    logic [2:0]  fb;
    logic [31:0] ws;
    logic [31:0] v;
    logic [2:0]  flen;
    status_t     st;

    ph                = phase_r;
    fb                = field_bytes_r;
    ws                = word_shift_r;
    skip_left_nxt     = skip_left_r;
    byte_position_nxt = byte_position_r;
    fmt_length_nxt    = fmt_length_r;
    format_tag_nxt    = format_tag_r;
    held_channels_nxt = held_channels_r;
    held_rate_nxt     = held_rate_r;
    held_depth_nxt    = held_depth_r;
    held_size_nxt     = held_size_r;
    error_code_nxt    = error_code_r;
    v                 = '0;
    st                = ST_PARSING;

    if (in_data.restart) begin
      ph                = PH_ID;
      fb                = '0;
      ws                = '0;
      skip_left_nxt     = '0;
      byte_position_nxt = '0;
      fmt_length_nxt    = '0;
      format_tag_nxt    = '0;
      held_channels_nxt = '0;
      held_rate_nxt     = '0;
      held_depth_nxt    = '0;
      held_size_nxt     = '0;
      error_code_nxt    = ERR_NONE;
    end

    case (ph)
      PH_FMT_TAG, PH_FMT_CH, PH_FMT_ALIGN, PH_FMT_DEPTH, PH_FMT_EXTRA: flen = 3'd2;
      default: flen = 3'd4;
    endcase

    if (error_code_nxt == ERR_NONE && ph == PH_DONE) begin
      st = ST_PAST;
    end else if (error_code_nxt == ERR_NONE) begin
      byte_position_nxt = byte_position_nxt + 32'd1;
      if (ph == PH_SKIP) begin
        skip_left_nxt = skip_left_nxt - 32'd1;
        if (skip_left_nxt == 32'd0) ph = PH_ID;
      end else begin
        ws = ws | ({24'd0, in_data.byte_in} << {fb[1:0], 3'b000});
        fb = fb + 3'd1;
        if (fb >= flen) begin
          v  = ws;
          fb = '0;
          ws = '0;
          unique case (ph)
            PH_ID: begin
              if (v == ID_RIFF)      ph = PH_RIFF_SIZE;
              else if (v == ID_FMT)  ph = PH_FMT_SIZE;
              else if (v == ID_DATA) ph = PH_DATA_SIZE;
              else                   ph = PH_SKIP_SIZE;
            end
            PH_RIFF_SIZE: ph = PH_RIFF_TYPE;
            PH_RIFF_TYPE: begin
              if (v != ID_WAVE) error_code_nxt = ERR_NOTWAV;
              ph = PH_ID;
            end
            PH_FMT_SIZE: begin
              fmt_length_nxt = v;
              ph = PH_FMT_TAG;
            end
            PH_FMT_TAG: begin
              format_tag_nxt = v[15:0];
              if (v[15:0] != FORMAT_PCM) error_code_nxt = ERR_NOTPCM;
              ph = PH_FMT_CH;
            end
            PH_FMT_CH: begin
              held_channels_nxt = v[15:0];
              ph = PH_FMT_RATE;
            end
            PH_FMT_RATE: begin
              held_rate_nxt = v;
              ph = PH_FMT_BRATE;
            end
            PH_FMT_BRATE: ph = PH_FMT_ALIGN;
            PH_FMT_ALIGN: ph = PH_FMT_DEPTH;
            PH_FMT_DEPTH: begin
              held_depth_nxt = v[15:0];
              ph = (fmt_length_nxt == FMT_WITH_EXTRA) ? PH_FMT_EXTRA : PH_ID;
            end
            PH_FMT_EXTRA: begin
              skip_left_nxt = {16'd0, v[15:0]};
              ph = (v[15:0] == 16'd0) ? PH_ID : PH_SKIP;
            end
            PH_DATA_SIZE: begin
              held_size_nxt = v;
              ph = PH_DONE;
              st = ST_DONE;
            end
            PH_SKIP_SIZE: begin
              skip_left_nxt = v;
              ph = (v == 32'd0) ? PH_ID : PH_SKIP;
            end
            default: ph = PH_ID;
          endcase
        end
      end
    end

    if (error_code_nxt == ERR_NOTPCM)      st = ST_NOTPCM;
    else if (error_code_nxt == ERR_NOTWAV) st = ST_NOTWAV;

    phase_nxt       = ph;
    field_bytes_nxt = fb;
    word_shift_nxt  = ws;

    out_data_nxt        = '0;
    out_data_nxt.status = st;
    if (st == ST_DONE || st == ST_PAST) begin
      out_data_nxt.channels        = held_channels_nxt;
      out_data_nxt.sample_rate     = held_rate_nxt;
      out_data_nxt.bits_per_sample = held_depth_nxt;
      out_data_nxt.payload_size    = held_size_nxt;
      out_data_nxt.payload_offset  = byte_position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_ID;
      field_bytes_r   <= '0;
      word_shift_r    <= '0;
      skip_left_r     <= '0;
      byte_position_r <= '0;
      fmt_length_r    <= '0;
      format_tag_r    <= '0;
      held_channels_r <= '0;
      held_rate_r     <= '0;
      held_depth_r    <= '0;
      held_size_r     <= '0;
      error_code_r    <= ERR_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r         <= phase_nxt;
        field_bytes_r   <= field_bytes_nxt;
        word_shift_r    <= word_shift_nxt;
        skip_left_r     <= skip_left_nxt;
        byte_position_r <= byte_position_nxt;
        fmt_length_r    <= fmt_length_nxt;
        format_tag_r    <= format_tag_nxt;
        held_channels_r <= held_channels_nxt;
        held_rate_r     <= held_rate_nxt;
        held_depth_r    <= held_depth_nxt;
        held_size_r     <= held_size_nxt;
        error_code_r    <= error_code_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= out_data_nxt;
  end

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output register not empty after reset");

  a_field_count: assert property (@(posedge clk) disable iff (!rst_n)
    field_bytes_r <= 3'd3)
    else $error("field byte count out of range");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_left_r != 32'd0)
    else $error("skip phase with zero count");

  a_past_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_data.restart && phase_r == PH_DONE && error_code_r == ERR_NONE
    |=> out_valid_r && out_data_r.status == ST_PAST)
    else $error("byte after header not reported as past header");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_data.restart && error_code_r != ERR_NONE
    |=> error_code_r == $past(error_code_r))
    else $error("error code changed without restart");

endmodule
